>>> rtl/duc_pkg.sv
package duc_pkg;

  localparam logic [2:0] KIND_SNAN   = 3'd0;
  localparam logic [2:0] KIND_QNAN   = 3'd1;
  localparam logic [2:0] KIND_ZERO   = 3'd2;
  localparam logic [2:0] KIND_FINITE = 3'd3;
  localparam logic [2:0] KIND_INF    = 3'd4;

  localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;
  localparam logic [11:0] EXP_BIAS     = 12'd1023;
  localparam logic [11:0] DENORM_EXP   = 12'hc02;  // -1022
  localparam int          QUIET_POS    = 51;

  // Payload between stages
  typedef struct packed {
    logic [2:0]  kind;
    logic        sign;
    logic [11:0] exponent;
    logic [60:0] mantissa;
    logic        denorm;
  } stage_t;

endpackage

>>> rtl/duc_shift_stage.sv
// One normalize step: shift a denormal left by SHIFT if its top SHIFT bits are clear.
module duc_shift_stage #(
  parameter int SHIFT = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  duc_pkg::stage_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output duc_pkg::stage_t  out_data
);

  duc_pkg::stage_t data_next;

  assign in_ready = !out_valid || out_ready;

  // Conditional shift for denormals only
  always_comb begin
    data_next = in_data;
    if (in_data.denorm && (in_data.mantissa[60 -: SHIFT] == '0)) begin
      data_next.mantissa = in_data.mantissa << SHIFT;
      data_next.exponent = in_data.exponent - 12'(SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

>>> rtl/duc_decode.sv
// Classify and unpack into the first pipeline register.
module duc_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [31:0]      high_word,
  input  logic [31:0]      low_word,
  output logic             out_valid,
  input  logic             out_ready,
  output duc_pkg::stage_t  out_data
);

  duc_pkg::stage_t data_next;
  logic [10:0] bexp;
  logic [51:0] frac;

  assign in_ready = !out_valid || out_ready;
  assign bexp = high_word[30:20];
  assign frac = {high_word[19:0], low_word};

  // Decode class fields
  always_comb begin
    data_next.sign     = high_word[31];
    data_next.exponent = '0;
    data_next.mantissa = '0;
    data_next.denorm   = 1'b0;
    if (bexp == '0) begin
      if (frac == '0) begin
        data_next.kind = duc_pkg::KIND_ZERO;
      end else begin
        data_next.kind     = duc_pkg::KIND_FINITE;
        data_next.exponent = duc_pkg::DENORM_EXP;
        data_next.mantissa = {1'b0, frac, 8'd0};
        data_next.denorm   = 1'b1;
      end
    end else if (bexp == duc_pkg::EXP_ALL_ONES) begin
      if (frac == '0) begin
        data_next.kind = duc_pkg::KIND_INF;
      end else begin
        data_next.kind     = frac[duc_pkg::QUIET_POS] ? duc_pkg::KIND_QNAN
                                                      : duc_pkg::KIND_SNAN;
        data_next.mantissa = {9'd0, frac};
      end
    end else begin
      data_next.kind     = duc_pkg::KIND_FINITE;
      data_next.exponent = {1'b0, bexp} - duc_pkg::EXP_BIAS;
      data_next.mantissa = {1'b1, frac, 8'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

>>> rtl/double_unpack_classify_unit.sv
// Channel | Signals                                  | Direction
// in      | in_valid, in_ready, high_word, low_word  | into block
// out     | out_valid, out_ready, kind, sign,        | out of block
//         | exponent, mantissa                       |
//
// One decode register, then six normalize stages that shift a denormal by
// 32, 16, 8, 4, 2, 1 bits where its top bits are clear.
// One transaction enters per cycle when the output is taken.
// A stall holds every stage whose successor is full and cannot pass its data on; nothing drops.
// Synchronous reset clears the valid bits only.
module double_unpack_classify_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] high_word,
  input  logic [31:0] low_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic        sign,
  output logic signed [11:0] exponent,
  output logic [60:0] mantissa
);

  localparam int NSTG = 6;

  logic            vld [NSTG+1];
  logic            rdy [NSTG+1];
  duc_pkg::stage_t dat [NSTG+1];

  duc_decode u_dec (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .high_word(high_word), .low_word(low_word),
    .out_valid(vld[0]), .out_ready(rdy[0]), .out_data(dat[0])
  );

  // Normalize chain, widest shift first
  for (genvar g = 0; g < NSTG; g++) begin : g_norm
    duc_shift_stage #(.SHIFT(32 >> g)) u_sh (
      .clk(clk), .rst(rst), .in_valid(vld[g]), .in_ready(rdy[g]),
      .in_data(dat[g]), .out_valid(vld[g+1]), .out_ready(rdy[g+1]),
      .out_data(dat[g+1])
    );
  end

  assign rdy[NSTG]  = out_ready;
  assign out_valid  = vld[NSTG];
  assign kind       = dat[NSTG].kind;
  assign sign       = dat[NSTG].sign;
  assign exponent   = dat[NSTG].exponent;
  assign mantissa   = dat[NSTG].mantissa;

endmodule
